@@ design/imu_sample_scale_rotate_unit_assert.svh @@
// Assertion macros used by the IMU scale and rotate checker.
`ifndef IMU_SAMPLE_SCALE_ROTATE_UNIT_ASSERT_SVH
`define IMU_SAMPLE_SCALE_ROTATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSR_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/imu_ssr_pkg.sv @@
// Package with types, constants and the step program of the IMU scale and rotate unit.
`default_nettype none

package imu_ssr_pkg;

    localparam int OUTPUT_FRACTION_BITS_DEFAULT = 16;
    localparam int INNER_FRAC   = 24;
    localparam int Q14_SHIFT    = 14;
    localparam int SCALE_SHIFT  = 22;

    localparam int ACC_W      = 64;
    localparam int OP_A_W     = 48;
    localparam int OP_B_W     = 16;
    localparam int V_W        = 38;
    localparam int P_W        = 40;
    localparam int SENS_W     = 29;
    localparam int RES_W      = 32;
    localparam int RAW_W      = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 6 * RES_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int GAINS_W    = 48;
    localparam int RANGE_W    = 2;
    localparam int NUM_STEPS  = 30;
    localparam int STEP_W     = 5;

    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_RANGE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_RANGE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_GAINS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_GAINS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MOUNT_ROT    = 3'd4;

    localparam logic [RANGE_W-1:0]    GYRO_RANGE_RESET  = 2'd2;
    localparam logic [RANGE_W-1:0]    ACCEL_RANGE_RESET = 2'd1;
    localparam logic [GAINS_W-1:0]    GAINS_RESET       = 48'h4000_4000_4000;
    localparam logic [CFG_DATA_W-1:0] MOUNT_ROT_RESET   = 64'h4000_0000_0000_0000;

    typedef enum logic [3:0] {
        A_SENS, A_ACC, A_V0, A_V1, A_V2, A_P0, A_P1, A_P2, A_P3
    } a_sel_t;

    typedef enum logic [3:0] {
        B_RAW0, B_RAW1, B_RAW2, B_GAIN0, B_GAIN1, B_GAIN2, B_W, B_UX, B_UY, B_UZ
    } b_sel_t;

    typedef enum logic [1:0] {
        OP_LOAD_POS, OP_LOAD_NEG, OP_ADD, OP_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        RND_NONE, RND_SCALE, RND_ROT, RND_OUT
    } rnd_t;

    typedef enum logic [3:0] {
        D_NONE, D_V0, D_V1, D_V2, D_P0, D_P1, D_P2, D_P3, D_R0, D_R1, D_R2
    } dest_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t op;
        rnd_t    rnd;
        dest_t   dest;
    } step_t;

    typedef struct packed {
        logic    mul_en;
        logic    acc_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t op;
        rnd_t    rnd;
        logic    wb_en;
        dest_t   wb_dest;
        logic    deliver;
    } ctrl_t;

    function automatic logic [SENS_W-1:0] gyro_sens(input logic [RANGE_W-1:0] code);
        logic [SENS_W-1:0] s;
        unique case (code)
            2'd0:    s = 29'd286331153;
            2'd1:    s = 29'd143165577;
            2'd2:    s = 29'd71582788;
            default: s = 29'd35791394;
        endcase
        return s;
    endfunction

    // Range code three falls back to the widest range.
    function automatic logic [SENS_W-1:0] accel_sens(input logic [RANGE_W-1:0] code);
        logic [SENS_W-1:0] s;
        unique case (code)
            2'd0:    s = 29'd2570754;
            2'd1:    s = 29'd5141509;
            default: s = 29'd10283018;
        endcase
        return s;
    endfunction

    function automatic step_t mk_step(input a_sel_t a, input b_sel_t b, input acc_op_t op,
                                      input rnd_t rnd, input dest_t d);
        step_t s;
        s.a_sel = a;
        s.b_sel = b;
        s.op    = op;
        s.rnd   = rnd;
        s.dest  = d;
        return s;
    endfunction

    // Scaling of the three axes, then p = q (0,v), then the vector part of p conj(q).
    function automatic step_t step_prog(input logic [STEP_W-1:0] idx);
        step_t s;
        unique case (idx)
            5'd0:    s = mk_step(A_SENS, B_RAW0,  OP_LOAD_POS, RND_NONE,  D_NONE);
            5'd1:    s = mk_step(A_ACC,  B_GAIN0, OP_LOAD_POS, RND_SCALE, D_V0);
            5'd2:    s = mk_step(A_SENS, B_RAW1,  OP_LOAD_POS, RND_NONE,  D_NONE);
            5'd3:    s = mk_step(A_ACC,  B_GAIN1, OP_LOAD_POS, RND_SCALE, D_V1);
            5'd4:    s = mk_step(A_SENS, B_RAW2,  OP_LOAD_POS, RND_NONE,  D_NONE);
            5'd5:    s = mk_step(A_ACC,  B_GAIN2, OP_LOAD_POS, RND_SCALE, D_V2);
            5'd6:    s = mk_step(A_V0,   B_UX,    OP_LOAD_NEG, RND_ROT,   D_NONE);
            5'd7:    s = mk_step(A_V1,   B_UY,    OP_SUB,      RND_ROT,   D_NONE);
            5'd8:    s = mk_step(A_V2,   B_UZ,    OP_SUB,      RND_ROT,   D_P0);
            5'd9:    s = mk_step(A_V0,   B_W,     OP_LOAD_POS, RND_ROT,   D_NONE);
            5'd10:   s = mk_step(A_V2,   B_UY,    OP_ADD,      RND_ROT,   D_NONE);
            5'd11:   s = mk_step(A_V1,   B_UZ,    OP_SUB,      RND_ROT,   D_P1);
            5'd12:   s = mk_step(A_V1,   B_W,     OP_LOAD_POS, RND_ROT,   D_NONE);
            5'd13:   s = mk_step(A_V0,   B_UZ,    OP_ADD,      RND_ROT,   D_NONE);
            5'd14:   s = mk_step(A_V2,   B_UX,    OP_SUB,      RND_ROT,   D_P2);
            5'd15:   s = mk_step(A_V2,   B_W,     OP_LOAD_POS, RND_ROT,   D_NONE);
            5'd16:   s = mk_step(A_V1,   B_UX,    OP_ADD,      RND_ROT,   D_NONE);
            5'd17:   s = mk_step(A_V0,   B_UY,    OP_SUB,      RND_ROT,   D_P3);
            5'd18:   s = mk_step(A_P0,   B_UX,    OP_LOAD_NEG, RND_OUT,   D_NONE);
            5'd19:   s = mk_step(A_P1,   B_W,     OP_ADD,      RND_OUT,   D_NONE);
            5'd20:   s = mk_step(A_P2,   B_UZ,    OP_SUB,      RND_OUT,   D_NONE);
            5'd21:   s = mk_step(A_P3,   B_UY,    OP_ADD,      RND_OUT,   D_R0);
            5'd22:   s = mk_step(A_P0,   B_UY,    OP_LOAD_NEG, RND_OUT,   D_NONE);
            5'd23:   s = mk_step(A_P2,   B_W,     OP_ADD,      RND_OUT,   D_NONE);
            5'd24:   s = mk_step(A_P3,   B_UX,    OP_SUB,      RND_OUT,   D_NONE);
            5'd25:   s = mk_step(A_P1,   B_UZ,    OP_ADD,      RND_OUT,   D_R1);
            5'd26:   s = mk_step(A_P0,   B_UZ,    OP_LOAD_NEG, RND_OUT,   D_NONE);
            5'd27:   s = mk_step(A_P3,   B_W,     OP_ADD,      RND_OUT,   D_NONE);
            5'd28:   s = mk_step(A_P1,   B_UY,    OP_SUB,      RND_OUT,   D_NONE);
            5'd29:   s = mk_step(A_P2,   B_UX,    OP_ADD,      RND_OUT,   D_R2);
            default: s = mk_step(A_SENS, B_RAW0,  OP_LOAD_POS, RND_NONE,  D_NONE);
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/imu_ssr_mac.sv @@
// Shared multiply-accumulate unit with a registered product and a rounding preload.
`default_nettype none

module imu_ssr_mac #(
    parameter int OUTPUT_FRACTION_BITS = imu_ssr_pkg::OUTPUT_FRACTION_BITS_DEFAULT
) (
    input  wire                                      clk,
    input  wire imu_ssr_pkg::ctrl_t                  ctrl,
    input  wire logic signed [imu_ssr_pkg::OP_A_W-1:0] op_a,
    input  wire logic signed [imu_ssr_pkg::OP_B_W-1:0] op_b,
    output logic signed [imu_ssr_pkg::ACC_W-1:0]     acc
);
    import imu_ssr_pkg::*;

    localparam int OUT_SH = INNER_FRAC - OUTPUT_FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] HALF_SCALE = 64'sd1 <<< (SCALE_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] HALF_ROT   = 64'sd1 <<< (Q14_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] HALF_OUT   =
        HALF_ROT + ((OUT_SH > 0) ? (64'sd1 <<< (Q14_SHIFT - 1 + OUT_SH)) : 64'sd0);

    logic signed [ACC_W-1:0] prod_full;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] half;

    assign prod_full = op_a * op_b;

    always_comb
    begin
        unique case (ctrl.rnd)
            RND_NONE:  half = '0;
            RND_SCALE: half = HALF_SCALE;
            RND_ROT:   half = HALF_ROT;
            RND_OUT:   half = HALF_OUT;
            default:   half = '0;
        endcase
        unique case (ctrl.op)
            OP_LOAD_POS: acc_next = half + prod_reg;
            OP_LOAD_NEG: acc_next = half - prod_reg;
            OP_ADD:      acc_next = acc_reg + prod_reg;
            OP_SUB:      acc_next = acc_reg - prod_reg;
            default:     acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full;
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ design/imu_ssr_ctrl.sv @@
// Sequencer that steps the shared multiply-accumulate unit through one sample.
`default_nettype none

module imu_ssr_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                is_accel,
    input  wire                out_free,
    output imu_ssr_pkg::ctrl_t ctrl,
    output logic               idle
);
    import imu_ssr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_FINISH, ST_DELIVER
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    dest_t             pend_reg;
    dest_t             pend_next;
    step_t             prog;

    always_comb
    begin
        prog       = step_prog(step_reg);
        ctrl       = '0;
        state_next = state_reg;
        step_next  = step_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                    pend_next  = D_NONE;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.a_sel   = prog.a_sel;
                ctrl.b_sel   = prog.b_sel;
                ctrl.wb_en   = (pend_reg != D_NONE);
                ctrl.wb_dest = pend_reg;
                pend_next    = D_NONE;
                state_next   = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_en = 1'b1;
                ctrl.op     = prog.op;
                ctrl.rnd    = prog.rnd;
                pend_next   = prog.dest;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                ctrl.wb_en   = (pend_reg != D_NONE);
                ctrl.wb_dest = pend_reg;
                pend_next    = D_NONE;
                state_next   = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (!is_accel)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    ctrl.deliver = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            pend_reg  <= D_NONE;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ design/imu_sample_scale_rotate_unit.sv @@
// Requests are taken only while the sequencer is idle, so one is processed at a time: the
// 30 multiply steps of the single shared multiplier, each a multiply state and an accumulate
// state, and for an accelerometer request the delivery, which a stalled output delays.
// Reset: asynchronous, active low; loads the register defaults, clears the held rate to zero
// and empties the output register.
`default_nettype none

module imu_sample_scale_rotate_unit #(
    parameter int OUTPUT_FRACTION_BITS = imu_ssr_pkg::OUTPUT_FRACTION_BITS_DEFAULT
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        s_tvalid,
    output logic                                       s_tready,
    // x_msb, x_lsb, y_msb, y_lsb, z_msb, z_lsb from the lowest bit up
    input  wire [imu_ssr_pkg::IN_DATA_W-1:0]           s_tdata,
    // action
    input  wire                                        s_tuser,
    output logic                                       m_tvalid,
    input  wire                                        m_tready,
    // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z from the lowest bit up
    output logic [imu_ssr_pkg::OUT_DATA_W-1:0]         m_tdata,
    input  wire                                        cfg_we,
    input  wire [imu_ssr_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire [imu_ssr_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import imu_ssr_pkg::*;

    localparam int OUT_SH = INNER_FRAC - OUTPUT_FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    logic [RANGE_W-1:0]    gyro_range_reg;
    logic [RANGE_W-1:0]    accel_range_reg;
    logic [GAINS_W-1:0]    gyro_gains_reg;
    logic [GAINS_W-1:0]    accel_gains_reg;
    logic [CFG_DATA_W-1:0] mount_rot_reg;

    logic                     action_reg;
    logic signed [RAW_W-1:0]  raw_reg [3];
    logic signed [V_W-1:0]    v_reg [3];
    logic signed [P_W-1:0]    p_reg [4];
    logic signed [RES_W-1:0]  accel_res_reg [3];
    logic signed [RES_W-1:0]  held_rate_reg [3];
    logic [OUT_DATA_W-1:0]    out_data_reg;
    logic                     out_valid_reg;

    ctrl_t                    ctrl;
    logic                     idle;
    logic                     accept;
    logic                     out_free;
    logic [GAINS_W-1:0]       gains_sel;
    logic [SENS_W-1:0]        sens_sel;
    logic signed [OP_A_W-1:0] op_a;
    logic signed [OP_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  r_full;
    logic signed [RES_W-1:0]  r_sat;
    logic signed [V_W-1:0]    v_wb;
    logic signed [P_W-1:0]    p_wb;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = idle;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_range_reg  <= GYRO_RANGE_RESET;
            accel_range_reg <= ACCEL_RANGE_RESET;
            gyro_gains_reg  <= GAINS_RESET;
            accel_gains_reg <= GAINS_RESET;
            mount_rot_reg   <= MOUNT_ROT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GYRO_RANGE:  gyro_range_reg  <= cfg_data[RANGE_W-1:0];
                REG_ACCEL_RANGE: accel_range_reg <= cfg_data[RANGE_W-1:0];
                REG_GYRO_GAINS:  gyro_gains_reg  <= cfg_data[GAINS_W-1:0];
                REG_ACCEL_GAINS: accel_gains_reg <= cfg_data[GAINS_W-1:0];
                REG_MOUNT_ROT:   mount_rot_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    imu_ssr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .is_accel (action_reg),
        .out_free (out_free),
        .ctrl     (ctrl),
        .idle     (idle)
    );

    assign gains_sel = action_reg ? accel_gains_reg : gyro_gains_reg;
    assign sens_sel  = action_reg ? accel_sens(accel_range_reg) : gyro_sens(gyro_range_reg);

    always_comb
    begin
        unique case (ctrl.a_sel)
            A_SENS:  op_a = $signed(OP_A_W'(sens_sel));
            A_ACC:   op_a = acc[OP_A_W-1:0];
            A_V0:    op_a = OP_A_W'(v_reg[0]);
            A_V1:    op_a = OP_A_W'(v_reg[1]);
            A_V2:    op_a = OP_A_W'(v_reg[2]);
            A_P0:    op_a = OP_A_W'(p_reg[0]);
            A_P1:    op_a = OP_A_W'(p_reg[1]);
            A_P2:    op_a = OP_A_W'(p_reg[2]);
            A_P3:    op_a = OP_A_W'(p_reg[3]);
            default: op_a = '0;
        endcase
        unique case (ctrl.b_sel)
            B_RAW0:  op_b = raw_reg[0];
            B_RAW1:  op_b = raw_reg[1];
            B_RAW2:  op_b = raw_reg[2];
            B_GAIN0: op_b = gains_sel[47:32];
            B_GAIN1: op_b = gains_sel[31:16];
            B_GAIN2: op_b = gains_sel[15:0];
            B_W:     op_b = mount_rot_reg[63:48];
            B_UX:    op_b = mount_rot_reg[47:32];
            B_UY:    op_b = mount_rot_reg[31:16];
            B_UZ:    op_b = mount_rot_reg[15:0];
            default: op_b = '0;
        endcase
    end

    imu_ssr_mac #(
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_mac (
        .clk  (clk),
        .ctrl (ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // The rounding offset was preloaded into the accumulator, so each write-back is a plain shift.
    assign v_wb   = V_W'(acc >>> SCALE_SHIFT);
    assign p_wb   = P_W'(acc >>> Q14_SHIFT);
    assign r_full = acc >>> (Q14_SHIFT + OUT_SH);

    always_comb
    begin
        priority if (r_full > SAT_MAX)
        begin
            r_sat = SAT_MAX[RES_W-1:0];
        end
        else if (r_full < SAT_MIN)
        begin
            r_sat = SAT_MIN[RES_W-1:0];
        end
        else
        begin
            r_sat = r_full[RES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= s_tuser;
            raw_reg[0] <= {s_tdata[7:0], s_tdata[15:8]};
            raw_reg[1] <= {s_tdata[23:16], s_tdata[31:24]};
            raw_reg[2] <= {s_tdata[39:32], s_tdata[47:40]};
        end
        if (ctrl.wb_en)
        begin
            unique case (ctrl.wb_dest)
                D_V0: v_reg[0] <= v_wb;
                D_V1: v_reg[1] <= v_wb;
                D_V2: v_reg[2] <= v_wb;
                D_P0: p_reg[0] <= p_wb;
                D_P1: p_reg[1] <= p_wb;
                D_P2: p_reg[2] <= p_wb;
                D_P3: p_reg[3] <= p_wb;
                D_R0: accel_res_reg[0] <= r_sat;
                D_R1: accel_res_reg[1] <= r_sat;
                D_R2: accel_res_reg[2] <= r_sat;
                default:
                begin
                end
            endcase
        end
    end

    // Only a gyro request updates the held rate; a gyro request delivers no output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_rate_reg[0] <= '0;
            held_rate_reg[1] <= '0;
            held_rate_reg[2] <= '0;
        end
        else if (ctrl.wb_en && !action_reg)
        begin
            unique case (ctrl.wb_dest)
                D_R0: held_rate_reg[0] <= r_sat;
                D_R1: held_rate_reg[1] <= r_sat;
                D_R2: held_rate_reg[2] <= r_sat;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.deliver)
        begin
            out_data_reg <= {accel_res_reg[2], accel_res_reg[1], accel_res_reg[0],
                             held_rate_reg[2], held_rate_reg[1], held_rate_reg[0]};
        end
    end

endmodule

`default_nettype wire

@@ design/imu_ssr_check.sv @@
// Port-level checker for the IMU scale and rotate unit and its bind statement.
`default_nettype none

`include "imu_sample_scale_rotate_unit_assert.svh"

module imu_ssr_check (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [imu_ssr_pkg::OUT_DATA_W-1:0]  m_tdata
);

    `SSR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed or dropped")

    `SSR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "unit took a request while still working")

    `SSR_ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result appeared without a request in progress")

endmodule

bind imu_sample_scale_rotate_unit imu_ssr_check u_ssr_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/imu_sample_scale_rotate_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the IMU sample scale and rotate unit, with its own bit-exact model.
module imu_sample_scale_rotate_unit_test;
    import imu_ssr_pkg::*;

    localparam int     OUT_FRAC       = OUTPUT_FRACTION_BITS_DEFAULT;
    localparam int     OUT_SHIFT      = INNER_FRAC - OUT_FRAC;
    localparam int     IDLE_PAUSE     = 80;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     HOLD_OFF       = 600;
    localparam int     NUM_PHASES     = 12;
    localparam int     PHASE_ITEMS    = 145;
    localparam int     PRESSURE_PHASE = 3;
    localparam int     MAX_PRINTS     = 40;
    localparam longint SAT_HI         = 64'sd2147483647;
    localparam longint SAT_LO         = -SAT_HI - 1;

    localparam longint GYRO_LSB_Q32 [4]  = '{286331153, 143165577, 71582788, 35791394};
    localparam longint ACCEL_LSB_Q32 [4] = '{2570754, 5141509, 10283018, 10283018};

    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = REG_MOUNT_ROT + 1'b1;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = '1;

    localparam logic [RANGE_W-1:0] GYRO_2000DPS      = 2'd0;
    localparam logic [RANGE_W-1:0] GYRO_250DPS       = 2'd3;
    localparam logic [RANGE_W-1:0] ACCEL_2G          = 2'd0;
    localparam logic [RANGE_W-1:0] ACCEL_RANGE_SPARE = 2'd3;

    localparam logic [15:0]           Q14_ONE  = 16'h4000;
    localparam logic [OUT_DATA_W-1:0] ALL_ZERO = '0;

    typedef enum logic {SAMPLE_GYRO = 1'b0, SAMPLE_ACCEL = 1'b1} sample_kind_e;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_e;

    typedef struct packed {
        logic signed [RES_W-1:0] x;
        logic signed [RES_W-1:0] y;
        logic signed [RES_W-1:0] z;
    } axes_t;

    // Raw axes are x, y, z from the top down; a fixed expectation is used where given.
    typedef struct packed {
        row_kind_e             kind;
        sample_kind_e          sample;
        logic [47:0]           axes;
        logic                  fixed_exp;
        logic [OUT_DATA_W-1:0] want;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } dir_row_t;

    localparam int NUM_DIR_ROWS = 32;
    localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h0000_0000_0000, 1'b1, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h7FFF_8000_0001, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h7FFF_8000_FFFF, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h8000_8000_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h8000_8000_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h7FFF_7FFF_7FFF, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'hFFFF_0001_7FFF, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_ACCEL_RANGE,
          {62'h0, ACCEL_RANGE_SPARE}},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h7FFF_7FFF_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_ACCEL_RANGE,
          {62'h3FFF_FFFF_FFFF_FFFF, ACCEL_2G}},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h8000_7FFF_0000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_GYRO_RANGE, {62'h0, GYRO_2000DPS}},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_GYRO_GAINS, 64'hFFFF_8000_8000_8000},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_MOUNT_ROT,  64'h7FFF_7FFF_7FFF_7FFF},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h8000_8000_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h7FFF_8000_7FFF, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_MOUNT_ROT,  64'h8000_8000_8000_8000},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_ACCEL_GAINS, 64'h0000_7FFF_8000_7FFF},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h7FFF_7FFF_7FFF, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h8000_8000_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_GYRO_RANGE, {62'h0, GYRO_250DPS}},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_UNMAPPED_LO, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_UNMAPPED_HI, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_GYRO_GAINS,  64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_ACCEL_GAINS, 64'h0},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h1234_ABCD_8001, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h7FFF_8000_FFFF, 1'b1, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_GYRO_GAINS,  64'h0000_4000_4000_4000},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_ACCEL_GAINS, 64'h0000_4000_4000_4000},
        '{ROW_CFG,  SAMPLE_GYRO,  48'h0, 1'b0, ALL_ZERO, REG_MOUNT_ROT,  64'h2D41_0000_0000_2D41},
        '{ROW_ITEM, SAMPLE_GYRO,  48'h7FFF_0100_8000, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0},
        '{ROW_ITEM, SAMPLE_ACCEL, 48'h0100_7FFF_FF00, 1'b0, ALL_ZERO, REG_GYRO_RANGE, 64'h0}
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [RANGE_W-1:0]    gyro_range_q  = GYRO_RANGE_RESET;
    logic [RANGE_W-1:0]    accel_range_q = ACCEL_RANGE_RESET;
    logic [GAINS_W-1:0]    gyro_gains_q  = GAINS_RESET;
    logic [GAINS_W-1:0]    accel_gains_q = GAINS_RESET;
    logic [CFG_DATA_W-1:0] mount_q       = MOUNT_ROT_RESET;
    axes_t                 held_rate_q   = '0;

    logic [OUT_DATA_W-1:0] frames_due [$];
    string                 field_names [6] = '{"rate_x", "rate_y", "rate_z",
                                               "accel_x", "accel_y", "accel_z"};
    int                    fail_count   = 0;
    int                    burst_left   = 0;
    int                    rx_hold      = 0;
    int                    rx_left      = 0;
    rx_mode_e              rx_mode      = RX_OPEN;
    int                    quiet_cycles = 0;

    imu_sample_scale_rotate_unit #(
        .OUTPUT_FRACTION_BITS(OUT_FRAC)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sext16(logic [15:0] h);
        return longint'($signed(h));
    endfunction

    function automatic logic signed [RES_W-1:0] sat_out(longint v);
        longint s;
        s = (OUT_SHIFT > 0) ? rnd_shr(v, OUT_SHIFT) : v;
        if (s > SAT_HI)
            s = SAT_HI;
        if (s < SAT_LO)
            s = SAT_LO;
        return s[RES_W-1:0];
    endfunction

    function automatic logic [IN_DATA_W-1:0] to_wire(logic [47:0] xyz);
        return {xyz[7:0], xyz[15:8], xyz[23:16], xyz[31:24], xyz[39:32], xyz[47:40]};
    endfunction

    // Sensitivity and per-axis gain in Q.24, then v' = q v q* as two Hamilton products.
    function automatic axes_t scale_rotate(logic [IN_DATA_W-1:0] d, logic [GAINS_W-1:0] g,
                                           longint lsb);
        longint v [3];
        longint qw, qx, qy, qz, p0, px, py, pz;
        axes_t  o;
        for (int i = 0; i < 3; i++)
            v[i] = rnd_shr(sext16({d[16*i +: 8], d[16*i+8 +: 8]}) * sext16(g[32-16*i +: 16])
                           * lsb, SCALE_SHIFT);
        qw = sext16(mount_q[63:48]);
        qx = sext16(mount_q[47:32]);
        qy = sext16(mount_q[31:16]);
        qz = sext16(mount_q[15:0]);
        p0 = rnd_shr(-(qx * v[0] + qy * v[1] + qz * v[2]), Q14_SHIFT);
        px = rnd_shr(qw * v[0] + qy * v[2] - qz * v[1], Q14_SHIFT);
        py = rnd_shr(qw * v[1] + qz * v[0] - qx * v[2], Q14_SHIFT);
        pz = rnd_shr(qw * v[2] + qx * v[1] - qy * v[0], Q14_SHIFT);
        o.x = sat_out(rnd_shr(-p0 * qx + qw * px - py * qz + pz * qy, Q14_SHIFT));
        o.y = sat_out(rnd_shr(-p0 * qy + qw * py - pz * qx + px * qz, Q14_SHIFT));
        o.z = sat_out(rnd_shr(-p0 * qz + qw * pz - px * qy + py * qx, Q14_SHIFT));
        return o;
    endfunction

    function automatic bit take_sample(sample_kind_e kind, logic [IN_DATA_W-1:0] d,
                                       output logic [OUT_DATA_W-1:0] frame);
        axes_t acc;
        frame = '0;
        if (kind == SAMPLE_GYRO)
        begin
            held_rate_q = scale_rotate(d, gyro_gains_q, GYRO_LSB_Q32[gyro_range_q]);
            return 1'b0;
        end
        acc = scale_rotate(d, accel_gains_q, ACCEL_LSB_Q32[accel_range_q]);
        frame = {acc.z, acc.y, acc.x, held_rate_q.z, held_rate_q.y, held_rate_q.x};
        return 1'b1;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return Q14_ONE;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_quat();
        real                   c [4];
        real                   norm;
        logic [CFG_DATA_W-1:0] q;
        q = {Q14_ONE, 48'h0};
        case ($urandom_range(0, 3))
            0: q = {Q14_ONE, 48'h0};
            1: q = {$urandom, $urandom};
            default:
            begin
                norm = 0.0;
                for (int i = 0; i < 4; i++)
                begin
                    c[i] = real'(int'($urandom_range(0, 2000)) - 1000);
                    norm += c[i] * c[i];
                end
                if (norm >= 1.0)
                    for (int i = 0; i < 4; i++)
                        q[48-16*i +: 16] = 16'($rtoi(c[i] / $sqrt(norm) * 16384.0));
            end
        endcase
        return q;
    endfunction

    task automatic note_failure(string msg);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_GYRO_RANGE:  gyro_range_q  = val[RANGE_W-1:0];
            REG_ACCEL_RANGE: accel_range_q = val[RANGE_W-1:0];
            REG_GYRO_GAINS:  gyro_gains_q  = val[GAINS_W-1:0];
            REG_ACCEL_GAINS: accel_gains_q = val[GAINS_W-1:0];
            REG_MOUNT_ROT:   mount_q       = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(sample_kind_e kind, logic [47:0] xyz, bit fixed,
                                logic [OUT_DATA_W-1:0] fixed_frame);
        logic [OUT_DATA_W-1:0] frame;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 90)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= to_wire(xyz);
        do
            @(posedge clk);
        while (!s_tready);
        if (take_sample(kind, to_wire(xyz), frame))
            frames_due.push_back(fixed ? fixed_frame : frame);
    endtask

    // Gyro requests give no result, so the unit may still be busy when the queue runs empty.
    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic randomize_regs(int phase);
        logic [CFG_DATA_W-1:0] junk;
        junk = {$urandom, $urandom};
        if (phase == 0)
        begin
            write_reg(REG_GYRO_RANGE, {junk[63:2], GYRO_2000DPS});
            write_reg(REG_ACCEL_RANGE, {junk[63:2], ACCEL_2G});
        end
        else if (phase == 1)
        begin
            write_reg(REG_GYRO_RANGE, {junk[63:2], GYRO_250DPS});
            write_reg(REG_ACCEL_RANGE, {junk[63:2], ACCEL_RANGE_SPARE});
        end
        else
        begin
            write_reg(REG_GYRO_RANGE, junk);
            write_reg(REG_ACCEL_RANGE, {$urandom, $urandom});
        end
        write_reg(REG_GYRO_GAINS, {junk[63:48], rand_gain(), rand_gain(), rand_gain()});
        write_reg(REG_ACCEL_GAINS, {junk[47:32], rand_gain(), rand_gain(), rand_gain()});
        write_reg(REG_MOUNT_ROT, rand_quat());
        write_reg(REG_UNMAPPED_LO + CFG_ADDR_W'($urandom_range(0, 2)), {$urandom, $urandom});
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frames_due.size() == 0)
                note_failure($sformatf("result %h with no request waiting", m_tdata));
            else
            begin
                want = frames_due.pop_front();
                for (int f = 0; f < 6; f++)
                    if (m_tdata[RES_W*f +: RES_W] !== want[RES_W*f +: RES_W])
                        note_failure($sformatf("%s got %0d want %0d", field_names[f],
                                               $signed(m_tdata[RES_W*f +: RES_W]),
                                               $signed(want[RES_W*f +: RES_W])));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int       n;
        int       pick;
        bit       dirty;
        dir_row_t row;
        dirty = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR_ROWS; i++)
        begin
            row = DIR_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                if (dirty)
                    drain_block();
                dirty = 1'b0;
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                send_request(row.sample, row.axes, row.fixed_exp, row.want);
                dirty = 1'b1;
            end
        end

        // Mostly gyro-then-accel pairs, as a sensor driver issues them, with lone samples mixed in.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_block();
            randomize_regs(p);
            if (p == PRESSURE_PHASE)
                rx_hold = HOLD_OFF;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    send_request(SAMPLE_GYRO, {rand_axis(), rand_axis(), rand_axis()}, 1'b0,
                                 ALL_ZERO);
                    send_request(SAMPLE_ACCEL, {rand_axis(), rand_axis(), rand_axis()}, 1'b0,
                                 ALL_ZERO);
                    n += 2;
                end
                else
                begin
                    send_request(pick < 8 ? SAMPLE_ACCEL : SAMPLE_GYRO,
                                 {rand_axis(), rand_axis(), rand_axis()}, 1'b0, ALL_ZERO);
                    n++;
                end
            end
        end

        drain_block();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
